>>> hw/rtl/isdf_pkg.sv
// Shared types and constants for the IPv4 source drop filter.
package isdf_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 1024;

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_INSTALL = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	localparam logic [1:0] KIND_VERDICT = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	localparam logic [2:0] CAUSE_COUNTED  = 3'd0;
	localparam logic [2:0] CAUSE_NOT_IPV4 = 3'd1;
	localparam logic [2:0] CAUSE_BAD_HDR  = 3'd2;
	localparam logic [2:0] CAUSE_OTHER_IF = 3'd3;
	localparam logic [2:0] CAUSE_NONE     = 3'd4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
	localparam logic [15:0] POS_MAX        = 16'hFFFF;
	localparam logic [3:0]  IHL_MIN        = 4'd5;

	typedef enum logic [1:0] {
		JOB_DONE,
		JOB_LOOKUP,
		JOB_INSTALL,
		JOB_READ
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [2:0]  cause;
		logic [31:0] key;
		logic [15:0] len;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP
	} back_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic        last;
		logic [15:0] ingress_if;
		logic [31:0] key_address;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        verdict;
		logic [15:0] egress_if;
		logic [2:0]  drop_cause;
		logic        found;
		logic        table_full;
		logic [63:0] packet_count;
		logic [63:0] byte_count;
	} result_t;

endpackage

>>> hw/rtl/isdf_front.sv
// Frame parser and classifier: turns accepted items into table jobs.
module isdf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  isdf_pkg::item_t     item,
	input  logic [15:0]         watched_if,
	output logic                job_push,
	output isdf_pkg::job_t      job
);

	logic [15:0] pos_q, pos_n;
	logic [15:0] eth_q, eth_n;
	logic [3:0]  ihl_q, ihl_n;
	logic [31:0] src_q, src_n;
	logic        is_byte;

	assign is_byte = (item.command == isdf_pkg::CMD_BYTE);

	always_comb begin
		pos_n = (pos_q == isdf_pkg::POS_MAX) ? pos_q : pos_q + 16'd1;
		eth_n = (pos_q == 16'd12 || pos_q == 16'd13) ? {eth_q[7:0], item.data_byte} : eth_q;
		ihl_n = (pos_q == 16'd14) ? item.data_byte[3:0] : ihl_q;
		src_n = (pos_q >= 16'd26 && pos_q <= 16'd29) ? {src_q[23:0], item.data_byte} : src_q;
	end

	always_comb begin
		job.key   = item.key_address;
		job.len   = pos_n;
		job.cause = isdf_pkg::CAUSE_NONE;
		job.kind  = isdf_pkg::JOB_DONE;
		job_push  = 1'b0;
		case (item.command)
			isdf_pkg::CMD_INSTALL: begin
				job.kind = isdf_pkg::JOB_INSTALL;
				job_push = accept;
			end
			isdf_pkg::CMD_READ: begin
				job.kind = isdf_pkg::JOB_READ;
				job_push = accept;
			end
			isdf_pkg::CMD_BYTE: begin
				job_push = accept & item.last;
				if (pos_n < isdf_pkg::ETH_HDR_LEN || eth_n != isdf_pkg::ETHERTYPE_IPV4) begin
					job.cause = isdf_pkg::CAUSE_NOT_IPV4;
				end else if (ihl_n < isdf_pkg::IHL_MIN
						|| pos_n < isdf_pkg::ETH_HDR_LEN + {10'd0, ihl_n, 2'b00}) begin
					job.cause = isdf_pkg::CAUSE_BAD_HDR;
				end else if (item.ingress_if != watched_if) begin
					job.cause = isdf_pkg::CAUSE_OTHER_IF;
				end else begin
					job.kind = isdf_pkg::JOB_LOOKUP;
					job.key  = src_n;
				end
			end
			default: begin
				job_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			eth_q <= '0;
			ihl_q <= '0;
			src_q <= '0;
		end else if (accept && is_byte) begin
			if (item.last) begin
				pos_q <= '0;
				eth_q <= '0;
				ihl_q <= '0;
				src_q <= '0;
			end else begin
				pos_q <= pos_n;
				eth_q <= eth_n;
				ihl_q <= ihl_n;
				src_q <= src_n;
			end
		end
	end

endmodule

>>> hw/rtl/isdf_queue.sv
// Two-entry job queue between the front and back parts.
module isdf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  isdf_pkg::job_t  push_job,
	input  logic            pop,
	output isdf_pkg::job_t  head,
	output logic            empty,
	output logic            full
);

	isdf_pkg::job_t slot_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/isdf_back.sv
// Table engine: sequential address search, counter update, install and read.
module isdf_back #(
	parameter int unsigned TABLE_ENTRIES = isdf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  isdf_pkg::job_t    head,
	input  logic              empty,
	output logic              pop,
	input  logic [15:0]       redirect_if,
	output logic              result_valid,
	output isdf_pkg::result_t result
);

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(TABLE_ENTRIES);

	logic [31:0] addr_mem [TABLE_ENTRIES];
	logic [63:0] pk_mem   [TABLE_ENTRIES];
	logic [63:0] by_mem   [TABLE_ENTRIES];

	isdf_pkg::back_state_t state_q, state_n;
	isdf_pkg::job_t        job_q;
	logic [CW-1:0]         idx_q, idx_n;
	logic [CW-1:0]         fill_q, fill_n;
	logic [31:0]           addr_rd;
	logic [63:0]           pk_rd, by_rd;
	logic                  rd_en;
	logic                  wr_en, wr_addr_en;
	logic [IW-1:0]         wr_idx;
	logic [63:0]           wr_pk, wr_by;
	logic                  res_en;
	isdf_pkg::result_t     res_n;
	logic                  take;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_rd <= addr_mem[idx_q[IW-1:0]];
			pk_rd   <= pk_mem[idx_q[IW-1:0]];
			by_rd   <= by_mem[idx_q[IW-1:0]];
		end
		if (wr_en) begin
			pk_mem[wr_idx] <= wr_pk;
			by_mem[wr_idx] <= wr_by;
		end
		if (wr_addr_en) begin
			addr_mem[wr_idx] <= job_q.key;
		end
	end

	always_comb begin
		state_n    = state_q;
		idx_n      = idx_q;
		fill_n     = fill_q;
		pop        = 1'b0;
		take       = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr_en = 1'b0;
		wr_idx     = idx_q[IW-1:0];
		wr_pk      = '0;
		wr_by      = '0;
		res_en     = 1'b0;
		res_n      = '0;
		res_n.drop_cause = isdf_pkg::CAUSE_NONE;
		case (state_q)
			isdf_pkg::ST_IDLE: begin
				if (!empty) begin
					pop  = 1'b1;
					take = 1'b1;
					idx_n = '0;
					if (head.kind == isdf_pkg::JOB_DONE) begin
						res_en           = 1'b1;
						res_n.kind       = isdf_pkg::KIND_VERDICT;
						res_n.drop_cause = head.cause;
					end else begin
						state_n = isdf_pkg::ST_SCAN;
					end
				end
			end
			isdf_pkg::ST_SCAN: begin
				if (idx_q == fill_q) begin
					// searched every installed entry without a match
					state_n = isdf_pkg::ST_IDLE;
					res_en  = 1'b1;
					case (job_q.kind)
						isdf_pkg::JOB_LOOKUP: begin
							res_n.kind      = isdf_pkg::KIND_VERDICT;
							res_n.verdict   = 1'b1;
							res_n.egress_if = redirect_if;
						end
						isdf_pkg::JOB_INSTALL: begin
							res_n.kind = isdf_pkg::KIND_ACK;
							if (fill_q != CNT_MAX) begin
								wr_en      = 1'b1;
								wr_addr_en = 1'b1;
								wr_idx     = fill_q[IW-1:0];
								fill_n     = fill_q + CW'(1);
							end else begin
								res_n.table_full = 1'b1;
							end
						end
						default: begin
							res_n.kind = isdf_pkg::KIND_READ;
						end
					endcase
				end else begin
					rd_en   = 1'b1;
					state_n = isdf_pkg::ST_CMP;
				end
			end
			isdf_pkg::ST_CMP: begin
				if (addr_rd == job_q.key) begin
					state_n     = isdf_pkg::ST_IDLE;
					res_en      = 1'b1;
					res_n.found = 1'b1;
					case (job_q.kind)
						isdf_pkg::JOB_LOOKUP: begin
							res_n.kind       = isdf_pkg::KIND_VERDICT;
							res_n.drop_cause = isdf_pkg::CAUSE_COUNTED;
							wr_en            = 1'b1;
							wr_pk            = pk_rd + 64'd1;
							wr_by            = by_rd + {48'd0, job_q.len};
						end
						isdf_pkg::JOB_INSTALL: begin
							res_n.kind = isdf_pkg::KIND_ACK;
							wr_en      = 1'b1;
						end
						default: begin
							res_n.kind         = isdf_pkg::KIND_READ;
							res_n.packet_count = pk_rd;
							res_n.byte_count   = by_rd;
						end
					endcase
				end else begin
					idx_n   = idx_q + CW'(1);
					state_n = isdf_pkg::ST_SCAN;
				end
			end
			default: begin
				state_n = isdf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= head;
		end
		if (res_en) begin
			result <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= isdf_pkg::ST_IDLE;
			idx_q        <= '0;
			fill_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_n;
			idx_q        <= idx_n;
			fill_q       <= fill_n;
			result_valid <= res_en;
		end
	end

endmodule

>>> hw/rtl/ipv4_source_drop_filter.sv
// Top level of the IPv4 source drop filter.
//
// Items enter on item with start; one is taken at each edge where start is
// high and busy is low. Frame bytes (command 0) are parsed as they arrive, one
// per cycle while busy is low; the last byte of a frame, an install and a read
// each become a job in a two-entry queue. busy is high only while that queue
// is full. Jobs are carried out in order by the table engine; each gives one
// result on result, marked by result_valid for exactly one cycle. The receiver
// cannot stall: results must be taken when shown. A job that needs no table
// search goes from the queue straight into the result register once the
// engine pops it. A search walks the installed entries one at a time through
// the memory read port, a scan state reading each entry and a compare state
// checking it against the key. Frame bytes that end no frame go on at one per
// cycle while the engine works, as long as the queue is not full.
// Write configuration (cfg_we, cfg_index, cfg_data) only while idle; the block
// does not enforce it. Reset clears parse state, queue, table fill count and
// both registers; the table then reads as empty, with no clearing pass.
module ipv4_source_drop_filter #(
	parameter int unsigned TABLE_ENTRIES = isdf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  isdf_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              result_valid,
	output isdf_pkg::result_t result
);

	logic [15:0]    watched_q, redirect_q;
	logic           accept, job_push, pop, empty, full;
	isdf_pkg::job_t job, head;

	assign busy   = full;
	assign accept = start & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_q  <= '0;
			redirect_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index) begin
				redirect_q <= cfg_data;
			end else begin
				watched_q <= cfg_data;
			end
		end
	end

	isdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.watched_if (watched_q),
		.job_push   (job_push),
		.job        (job)
	);

	isdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	isdf_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.redirect_if  (redirect_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the IPv4 source drop filter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NENT       = 1024;
	localparam logic        REG_WATCH  = 1'b0;
	localparam logic        REG_REDIR  = 1'b1;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam longint      LIMIT      = 8_000_000;
	localparam int          RAND_ITEMS = 700;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	isdf_pkg::item_t   item = '0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [15:0]       cfg_data = '0;
	logic              result_valid;
	isdf_pkg::result_t result;

	ipv4_source_drop_filter #(.TABLE_ENTRIES(NENT)) i_dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [15:0] watched_q, redirect_q;
	logic [15:0] pos_q, etype_q;
	logic [3:0]  ihl_q;
	logic [31:0] src_q;
	int          fill_q;
	logic [31:0] tbl_addr [NENT];
	logic [63:0] tbl_pkts [NENT];
	logic [63:0] tbl_bytes [NENT];

	isdf_pkg::result_t pending_q[$];
	int          mismatches = 0;
	longint      cycles = 0;
	bit          quiet = 0;
	logic [31:0] pool [10];

	typedef struct {
		isdf_pkg::item_t   it;
		bit                typed;
		isdf_pkg::result_t exp;
	} row_t;
	row_t rows[$];

	function automatic isdf_pkg::result_t mk_res(logic [1:0] k, logic v, logic [15:0] eg,
			logic [2:0] c, logic f, logic full, logic [63:0] pk, logic [63:0] by);
		isdf_pkg::result_t r;
		r = '{kind: k, verdict: v, egress_if: eg, drop_cause: c, found: f,
			table_full: full, packet_count: pk, byte_count: by};
		return r;
	endfunction

	function automatic isdf_pkg::item_t mk_item(logic [1:0] c, logic [7:0] b, logic l,
			logic [15:0] ifc, logic [31:0] key);
		isdf_pkg::item_t t;
		t = '{command: c, data_byte: b, last: l, ingress_if: ifc, key_address: key};
		return t;
	endfunction

	function automatic int lookup(logic [31:0] a);
		for (int i = 0; i < fill_q; i++)
			if (tbl_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic bit filter_step(isdf_pkg::item_t it, output isdf_pkg::result_t r);
		int e;
		int len;
		r = mk_res(isdf_pkg::KIND_VERDICT, 1'b0, 16'd0, isdf_pkg::CAUSE_NONE, 1'b0, 1'b0,
			64'd0, 64'd0);
		if (it.command == isdf_pkg::CMD_INSTALL) begin
			e = lookup(it.key_address);
			r.kind = isdf_pkg::KIND_ACK;
			if (e >= 0) begin
				tbl_pkts[e] = '0;
				tbl_bytes[e] = '0;
				r.found = 1'b1;
			end else if (fill_q < NENT) begin
				tbl_addr[fill_q] = it.key_address;
				tbl_pkts[fill_q] = '0;
				tbl_bytes[fill_q] = '0;
				fill_q++;
			end else
				r.table_full = 1'b1;
			return 1;
		end
		if (it.command == isdf_pkg::CMD_READ) begin
			e = lookup(it.key_address);
			r.kind = isdf_pkg::KIND_READ;
			if (e >= 0) begin
				r.found = 1'b1;
				r.packet_count = tbl_pkts[e];
				r.byte_count = tbl_bytes[e];
			end
			return 1;
		end
		if (it.command != isdf_pkg::CMD_BYTE) return 0;
		if (pos_q == 12 || pos_q == 13) etype_q = {etype_q[7:0], it.data_byte};
		else if (pos_q == 14) ihl_q = it.data_byte[3:0];
		else if (pos_q >= 26 && pos_q <= 29) src_q = {src_q[23:0], it.data_byte};
		if (pos_q != isdf_pkg::POS_MAX) pos_q++;
		if (!it.last) return 0;
		len = pos_q;
		if (len < isdf_pkg::ETH_HDR_LEN || etype_q != isdf_pkg::ETHERTYPE_IPV4)
			r.drop_cause = isdf_pkg::CAUSE_NOT_IPV4;
		else if (ihl_q < isdf_pkg::IHL_MIN || len < isdf_pkg::ETH_HDR_LEN + ihl_q * 4)
			r.drop_cause = isdf_pkg::CAUSE_BAD_HDR;
		else if (it.ingress_if != watched_q)
			r.drop_cause = isdf_pkg::CAUSE_OTHER_IF;
		else begin
			e = lookup(src_q);
			if (e >= 0) begin
				tbl_pkts[e] += 64'd1;
				tbl_bytes[e] += 64'(len);
				r.drop_cause = isdf_pkg::CAUSE_COUNTED;
				r.found = 1'b1;
			end else begin
				r.verdict = 1'b1;
				r.egress_if = redirect_q;
			end
		end
		pos_q = '0;
		etype_q = '0;
		ihl_q = '0;
		src_q = '0;
		return 1;
	endfunction

	// one transfer; called right after a rising edge
	task automatic push_item(isdf_pkg::item_t it, bit typed = 0,
			isdf_pkg::result_t exp = '0);
		isdf_pkg::result_t r;
		bit ok;
		while (!quiet && $urandom_range(99) < 9) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
		if (filter_step(it, r)) pending_q.push_back(typed ? exp : r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (2 * fill_q + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 16'($urandom);
		if (idx == REG_WATCH) watched_q = v;
		else redirect_q = v;
		@(posedge clk);
	endtask

	// frame bytes: ethertype, IHL byte and source placed, rest random;
	// with cmd_mix, installs and reads get slipped between bytes
	task automatic send_frame(int len, logic [15:0] et, logic [7:0] vihl,
			logic [31:0] src, logic [15:0] ifc, bit cmd_mix);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 12) b = et[15:8];
			else if (i == 13) b = et[7:0];
			else if (i == 14) b = vihl;
			else if (i >= 26 && i <= 29) b = src[8 * (29 - i) +: 8];
			if (cmd_mix && $urandom_range(99) < 4)
				push_item(mk_item($urandom_range(1) ? isdf_pkg::CMD_INSTALL
					: isdf_pkg::CMD_READ,
					8'($urandom), 1'($urandom), 16'($urandom),
					pool[$urandom_range(9)]));
			push_item(mk_item(isdf_pkg::CMD_BYTE, b, i == len - 1, ifc, $urandom));
		end
	endtask

	task automatic rand_frame();
		int ihl, len, k;
		logic [15:0] et, ifc;
		logic [31:0] src;
		ihl = ($urandom_range(3) != 0) ? 5 : $urandom_range(5, 15);
		len = 14 + 4 * ihl + $urandom_range(0, 24);
		et = isdf_pkg::ETHERTYPE_IPV4;
		src = pool[$urandom_range(9)];
		ifc = ($urandom_range(9) < 8) ? watched_q : 16'($urandom);
		k = $urandom_range(99);
		if (k < 8) et = 16'($urandom);
		else if (k < 14) ihl = $urandom_range(0, 4);
		else if (k < 20) len = $urandom_range(15, 14 + 4 * ihl - 1);
		else if (k < 25) len = $urandom_range(1, 20);
		else if (k < 28) src = $urandom;
		send_frame(len, et, {4'($urandom), 4'(ihl)}, src, ifc, 1);
	endtask

	task automatic rand_phase(int n);
		int k, goal;
		goal = n;
		while (goal > 0) begin
			k = $urandom_range(99);
			if (k < 70) begin
				rand_frame();
				goal -= 40;
			end else begin
				if (k < 80)
					push_item(mk_item(isdf_pkg::CMD_INSTALL, 8'($urandom),
						1'($urandom), 16'($urandom), ($urandom_range(9) == 0)
						? $urandom : pool[$urandom_range(9)]));
				else if (k < 97)
					push_item(mk_item(isdf_pkg::CMD_READ, 8'($urandom),
						1'($urandom), 16'($urandom), ($urandom_range(5) == 0)
						? $urandom : pool[$urandom_range(9)]));
				else
					push_item(mk_item(CMD_UNUSED, 8'($urandom), 1'($urandom),
						16'($urandom), $urandom));
				goal--;
			end
		end
	endtask

	// result checker; results sampled mid-cycle
	always @(negedge clk) begin
		isdf_pkg::result_t e;
		if (arst_n && result_valid) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", result);
			end else begin
				e = pending_q.pop_front();
				if (result.kind !== e.kind || result.verdict !== e.verdict ||
						result.egress_if !== e.egress_if ||
						result.drop_cause !== e.drop_cause ||
						result.found !== e.found || result.table_full !== e.table_full ||
						result.packet_count !== e.packet_count ||
						result.byte_count !== e.byte_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		watched_q = '0; redirect_q = '0; pos_q = '0; etype_q = '0;
		ihl_q = '0; src_q = '0; fill_q = 0;
		pool[0] = 32'h0A000001;
		pool[1] = 32'h00000000;
		pool[2] = 32'hFFFFFFFF;
		for (int i = 3; i < 10; i++) pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows with hand-typed results where obvious
		rows.push_back('{mk_item(isdf_pkg::CMD_READ, 8'hFF, 1'b1, 16'hFFFF, pool[0]), 1,
			mk_res(isdf_pkg::KIND_READ, 0, 0, isdf_pkg::CAUSE_NONE, 0, 0, 0, 0)});
		rows.push_back('{mk_item(isdf_pkg::CMD_INSTALL, 8'h00, 1'b0, 16'h0000, pool[0]), 1,
			mk_res(isdf_pkg::KIND_ACK, 0, 0, isdf_pkg::CAUSE_NONE, 0, 0, 0, 0)});
		rows.push_back('{mk_item(isdf_pkg::CMD_INSTALL, 8'hFF, 1'b1, 16'hFFFF, pool[0]), 1,
			mk_res(isdf_pkg::KIND_ACK, 0, 0, isdf_pkg::CAUSE_NONE, 1, 0, 0, 0)});
		rows.push_back('{mk_item(CMD_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF), 0, '0});
		rows.push_back('{mk_item(isdf_pkg::CMD_BYTE, 8'hFF, 1'b1, 16'h0000, 32'h0), 1,
			mk_res(isdf_pkg::KIND_VERDICT, 0, 0, isdf_pkg::CAUSE_NOT_IPV4, 0, 0, 0, 0)});
		rows.push_back('{mk_item(isdf_pkg::CMD_INSTALL, 8'h00, 1'b0, 16'h0000, pool[1]),
			0, '0});
		rows.push_back('{mk_item(isdf_pkg::CMD_INSTALL, 8'h00, 1'b0, 16'h0000, pool[2]),
			0, '0});
		rows.push_back('{mk_item(isdf_pkg::CMD_READ, 8'h00, 1'b0, 16'h0000, pool[2]), 1,
			mk_res(isdf_pkg::KIND_READ, 0, 0, isdf_pkg::CAUSE_NONE, 1, 0, 0, 0)});
		foreach (rows[i]) push_item(rows[i].it, rows[i].typed, rows[i].exp);
		send_frame(34, isdf_pkg::ETHERTYPE_IPV4, 8'h45, pool[0], 16'h0000, 0);
		send_frame(34, isdf_pkg::ETHERTYPE_IPV4, 8'h45, pool[5], 16'h0000, 0);
		send_frame(34, isdf_pkg::ETHERTYPE_IPV4, 8'h44, pool[0], 16'h0000, 0);
		send_frame(40, isdf_pkg::ETHERTYPE_IPV4, 8'h4F, pool[0], 16'h0000, 0);
		send_frame(20, 16'h86DD, 8'h45, pool[0], 16'h0000, 0);
		send_frame(34, isdf_pkg::ETHERTYPE_IPV4, 8'h45, pool[2], 16'h1234, 0);
		send_frame(60, isdf_pkg::ETHERTYPE_IPV4, 8'h45, pool[2], 16'h0000, 0);
		push_item(mk_item(isdf_pkg::CMD_READ, 8'h00, 1'b0, 16'h0000, pool[2]));
		push_item(mk_item(isdf_pkg::CMD_READ, 8'h00, 1'b0, 16'h0000, pool[0]));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_WATCH, 16'($urandom));
					write_reg(REG_REDIR, 16'($urandom));
				end
				1: begin
					write_reg(REG_WATCH, 16'h0000);
					write_reg(REG_REDIR, 16'hFFFF);
				end
				2: begin
					write_reg(REG_WATCH, 16'hFFFF);
					write_reg(REG_REDIR, 16'h0000);
				end
				default: begin
					write_reg(REG_WATCH, 16'($urandom));
					write_reg(REG_REDIR, 16'($urandom));
				end
			endcase
			@(posedge clk);
			quiet = (ph == 2);
			rand_phase(RAND_ITEMS / 4);
			drain();
		end
		quiet = 0;

		// fill the table, then overflow it
		for (int i = fill_q; i < NENT; i++)
			push_item(mk_item(isdf_pkg::CMD_INSTALL, 8'($urandom), 1'($urandom),
				16'($urandom), 32'hC0A80000 + i));
		push_item(mk_item(isdf_pkg::CMD_INSTALL, 8'h00, 1'b0, 16'h0000, 32'h01020304), 1,
			mk_res(isdf_pkg::KIND_ACK, 0, 0, isdf_pkg::CAUSE_NONE, 0, 1, 0, 0));
		send_frame(34, isdf_pkg::ETHERTYPE_IPV4, 8'h45, 32'h01020304, watched_q, 0);
		send_frame(34, isdf_pkg::ETHERTYPE_IPV4, 8'h45, 32'hC0A80000 + NENT - 1,
			watched_q, 0);
		push_item(mk_item(isdf_pkg::CMD_READ, 8'h00, 1'b0, 16'h0000,
			32'hC0A80000 + NENT - 1));
		drain();

		if (mismatches == 0 && pending_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> ipv4_source_drop_filter.f
hw/rtl/isdf_pkg.sv
hw/rtl/isdf_front.sv
hw/rtl/isdf_queue.sv
hw/rtl/isdf_back.sv
hw/rtl/ipv4_source_drop_filter.sv
bench/tb_top.sv
